[rtl/hsd_pkg.sv]
// shared types, constants and command and status structs of the hit selector
`default_nettype none

package hsd_pkg;

    // default store depth
    localparam int HSD_HIT_CAPACITY = 64;

    // field widths
    localparam int ID_W     = 12;
    localparam int VIEW_W   = 2;
    localparam int ENERGY_W = 16;
    localparam int CELL_W   = 16;
    localparam int POS_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 16;

    // view codes
    localparam logic [VIEW_W-1:0] VIEW_U     = 2'd0;
    localparam logic [VIEW_W-1:0] VIEW_OTHER = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ENERGY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CELL_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CELL_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_AVAIL = 2'd3;

    // configuration reset values
    localparam logic [CFG_W-1:0] RST_MIN_ENERGY   = 16'd1;
    localparam logic [CFG_W-1:0] RST_MIN_CELL_LEN = 16'd1;
    localparam logic [CFG_W-1:0] RST_MAX_CELL_LEN = 16'd512;
    localparam logic             RST_REQUIRE_AVAIL = 1'b1;

    // one incoming hit
    typedef struct packed {
        logic [POS_W-1:0]    pos_z;
        logic [POS_W-1:0]    pos_y;
        logic [POS_W-1:0]    pos_x;
        logic [CELL_W-1:0]   cell_length;
        logic [ENERGY_W-1:0] raw_energy;
        logic [ENERGY_W-1:0] equiv_energy;
        logic                available;
        logic [VIEW_W-1:0]   view;
        logic [ID_W-1:0]     hit_id;
    } t_hit_in;

    // one stored hit
    typedef struct packed {
        logic [POS_W-1:0]    pos_z;
        logic [POS_W-1:0]    pos_y;
        logic [POS_W-1:0]    pos_x;
        logic [ENERGY_W-1:0] energy;
        logic [VIEW_W-1:0]   view;
        logic [ID_W-1:0]     id;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load_ready;  // take input requests
        logic i_clr;       // restart outer index
        logic i_inc;       // next outer hit
        logic j_clr;       // restart inner scan
        logic scan;        // issue inner read and step
        logic push;        // current hit kept
        logic final_emit;  // close the event on the output
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic eoe_accept;  // last hit of event accepted
        logic i_done;      // outer index reached hit count
        logic j_last;      // inner index on last stored hit
        logic shadowed;    // current hit has a stronger twin
        logic out_free;    // output register can take a result
    } t_status;

endpackage

`default_nettype wire

[rtl/hit_select_and_dedup.sv]
// Hit selector and deduplicator, top level.
//
// Input stream (s side): one detector hit per request, tlast marks the last
// hit of an event. Hits are screened on arrival and passing hits go into a
// store of HIT_CAPACITY entries; hits beyond that are lost and flagged.
// The input stays ready throughout the load phase, so no hit waits there.
// After the last hit, an end pass compares each stored hit against every
// stored hit through the two read ports of the store, one pair per cycle
// while the inner scan runs. No input request is taken in the end pass.
// Output stream (m side): one request per kept hit in load order, tlast on
// the final one; an event with no kept hit gives one request with
// kept_valid clear. Results are held in an output register and one kept
// hit waits in a pending slot, so a stalled receiver only holds up the
// end pass and never loses or repeats a result.
// Configuration writes take effect at once; they must be made between
// events, which the block does not enforce. Reset (synchronous, active low)
// empties the store, clears the output and restores the register defaults.
`default_nettype none

module hit_select_and_dedup
    import hsd_pkg::*;
#(
    parameter int HIT_CAPACITY = HSD_HIT_CAPACITY
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // configuration write port
    input  wire                   i_cfg_wen,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_W-1:0]       i_cfg_wdata,
    // hit stream
    input  wire                   i_s_tvalid,
    output logic                  o_s_tready,
    // hit_id, view, available, equiv_energy, raw_energy, cell_length,
    // pos_x, pos_y, pos_z, one pad bit
    input  wire [IN_DATA_W-1:0]   i_s_tdata,
    input  wire                   i_s_tlast,
    // result stream
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    // kept_id, kept_view, kept_valid, overflowed
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast
);

    t_hit_in           hit;
    t_cmd              cmd;
    t_status           status;
    logic [ID_W-1:0]   kept_id;
    logic [VIEW_W-1:0] kept_view;
    logic              kept_valid;
    logic              overflowed;

    // unpack the request
    assign hit = t_hit_in'(i_s_tdata[$bits(t_hit_in)-1:0]);

    hsd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    hsd_datapath #(
        .HIT_CAPACITY (HIT_CAPACITY)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_s_tvalid),
        .i_hit        (hit),
        .i_in_last    (i_s_tlast),
        .i_out_ready  (i_m_tready),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_m_tvalid),
        .o_kept_id    (kept_id),
        .o_kept_view  (kept_view),
        .o_kept_valid (kept_valid),
        .o_overflowed (overflowed),
        .o_last       (o_m_tlast)
    );

    // pack the result
    assign o_s_tready = cmd.load_ready;
    assign o_m_tdata  = {overflowed, kept_valid, kept_view, kept_id};

endmodule

`default_nettype wire

[rtl/hsd_ctrl.sv]
// controller of the hit selector: load phase, duplicate scan and emission
`default_nettype none

module hsd_ctrl
    import hsd_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_ISTART,
        S_SCAN,
        S_SETTLE,
        S_DECIDE,
        S_FINAL
    } t_state;

    t_state r_state;
    t_state n_state;

    // commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load_ready = 1'b1;
                if (i_status.eoe_accept) begin
                    o_cmd.i_clr = 1'b1;
                    n_state     = S_ISTART;
                end
            end
            S_ISTART: begin
                if (i_status.i_done) begin
                    n_state = S_FINAL;
                end else begin
                    o_cmd.j_clr = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.j_last) begin
                    n_state = S_SETTLE;
                end
            end
            S_SETTLE: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_status.shadowed) begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = S_ISTART;
                end else if (i_status.out_free) begin
                    o_cmd.push  = 1'b1;
                    o_cmd.i_inc = 1'b1;
                    n_state     = S_ISTART;
                end
            end
            S_FINAL: begin
                if (i_status.out_free) begin
                    o_cmd.final_emit = 1'b1;
                    n_state          = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[rtl/hsd_datapath.sv]
// datapath of the hit selector: screening, hit store, pair compare, output register
`default_nettype none

module hsd_datapath
    import hsd_pkg::*;
#(
    parameter int HIT_CAPACITY = HSD_HIT_CAPACITY
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_wen,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_W-1:0]      i_cfg_wdata,
    input  wire                  i_in_valid,
    input  t_hit_in              i_hit,
    input  wire                  i_in_last,
    input  wire                  i_out_ready,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    output logic                 o_out_valid,
    output logic [ID_W-1:0]      o_kept_id,
    output logic [VIEW_W-1:0]    o_kept_view,
    output logic                 o_kept_valid,
    output logic                 o_overflowed,
    output logic                 o_last
);

    localparam int CNT_W  = $clog2(HIT_CAPACITY + 1);
    localparam int ADDR_W = $clog2(HIT_CAPACITY);

    // configuration registers
    logic [CFG_W-1:0] r_min_energy;
    logic [CFG_W-1:0] r_min_cell;
    logic [CFG_W-1:0] r_max_cell;
    logic             r_req_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_energy <= RST_MIN_ENERGY;
            r_min_cell   <= RST_MIN_CELL_LEN;
            r_max_cell   <= RST_MAX_CELL_LEN;
            r_req_avail  <= RST_REQUIRE_AVAIL;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index)
                CFG_MIN_ENERGY:    r_min_energy <= i_cfg_wdata;
                CFG_MIN_CELL_LEN:  r_min_cell   <= i_cfg_wdata;
                CFG_MAX_CELL_LEN:  r_max_cell   <= i_cfg_wdata;
                CFG_REQUIRE_AVAIL: r_req_avail  <= i_cfg_wdata[0];
            endcase
        end
    end

    // counters and flags
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] r_j;
    logic             r_ovf;

    // screening of the incoming request
    logic accept;
    logic pass;
    logic room;
    logic store;

    assign accept = i_cmd.load_ready && i_in_valid;
    assign pass   = !(r_req_avail && !i_hit.available)
                 && (i_hit.equiv_energy >= r_min_energy)
                 && (i_hit.cell_length >= r_min_cell)
                 && (i_hit.cell_length <= r_max_cell)
                 && (i_hit.raw_energy != '0)
                 && (i_hit.view != VIEW_OTHER);
    assign room   = r_count < CNT_W'(HIT_CAPACITY);
    assign store  = accept && pass && room;

    // hit store, one write port and two registered read ports
    t_entry r_mem [HIT_CAPACITY];
    t_entry r_a;
    t_entry r_b;
    t_entry n_wr;

    always_comb begin
        n_wr.id     = i_hit.hit_id;
        n_wr.view   = i_hit.view;
        n_wr.energy = i_hit.equiv_energy;
        n_wr.pos_x  = i_hit.pos_x;
        n_wr.pos_y  = i_hit.pos_y;
        n_wr.pos_z  = i_hit.pos_z;
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_mem[r_count[ADDR_W-1:0]] <= n_wr;
        end
        r_a <= r_mem[r_i[ADDR_W-1:0]];
        r_b <= r_mem[r_j[ADDR_W-1:0]];
    end

    // output register and pending kept hit
    logic              r_out_v;
    logic [ID_W-1:0]   r_out_id;
    logic [VIEW_W-1:0] r_out_view;
    logic              r_out_kv;
    logic              r_out_ovf;
    logic              r_out_last;
    logic              r_pend_v;
    logic [ID_W-1:0]   r_pend_id;
    logic [VIEW_W-1:0] r_pend_view;
    logic              out_free;
    logic              out_load;

    assign out_free = !r_out_v || i_out_ready;
    assign out_load = (i_cmd.push && r_pend_v) || i_cmd.final_emit;

    // inner compare pipeline
    logic             r_bv;
    logic [CNT_W-1:0] r_bj;
    logic             r_shadow;
    logic             twin;

    assign twin = r_bv && (r_bj != r_i)
               && (r_b.view == r_a.view)
               && (r_b.pos_x == r_a.pos_x)
               && (r_b.pos_y == r_a.pos_y)
               && (r_b.pos_z == r_a.pos_z)
               && (r_b.energy > r_a.energy);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_bv     <= 1'b0;
            r_shadow <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            // load counting and overflow
            if (store) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (accept && pass && !room) begin
                r_ovf <= 1'b1;
            end
            // outer index
            if (i_cmd.i_clr) begin
                r_i <= '0;
            end else if (i_cmd.i_inc) begin
                r_i <= r_i + CNT_W'(1);
            end
            // inner index
            if (i_cmd.j_clr) begin
                r_j <= '0;
            end else if (i_cmd.scan) begin
                r_j <= r_j + CNT_W'(1);
            end
            r_bv <= i_cmd.scan;
            // shadow flag for the current hit
            if (i_cmd.j_clr) begin
                r_shadow <= 1'b0;
            end else if (twin) begin
                r_shadow <= 1'b1;
            end
            // pending kept hit
            if (i_cmd.push) begin
                r_pend_v <= 1'b1;
            end
            // output handshake
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            // end of event clears the store
            if (i_cmd.final_emit) begin
                r_count  <= '0;
                r_ovf    <= 1'b0;
                r_pend_v <= 1'b0;
            end
        end
    end

    // compare index is registered together with the inner read data
    always_ff @(posedge i_clk) begin
        r_bj <= r_j;
    end

    // payload of pending and output
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_pend_id   <= r_a.id;
            r_pend_view <= r_a.view;
        end
        if (out_load) begin
            r_out_ovf <= r_ovf;
            if (r_pend_v) begin
                r_out_id   <= r_pend_id;
                r_out_view <= r_pend_view;
                r_out_kv   <= 1'b1;
            end else begin
                r_out_id   <= '0;
                r_out_view <= VIEW_U;
                r_out_kv   <= 1'b0;
            end
            r_out_last <= i_cmd.final_emit;
        end
    end

    // status to the controller
    always_comb begin
        o_status.eoe_accept = accept && i_in_last;
        o_status.i_done     = (r_i == r_count);
        o_status.j_last     = ((r_j + CNT_W'(1)) == r_count);
        o_status.shadowed   = r_shadow;
        o_status.out_free   = out_free;
    end

    assign o_out_valid  = r_out_v;
    assign o_kept_id    = r_out_id;
    assign o_kept_view  = r_out_view;
    assign o_kept_valid = r_out_kv;
    assign o_overflowed = r_out_ovf;
    assign o_last       = r_out_last;

endmodule

`default_nettype wire

[rtl/hsd_checker.sv]
// port checker of the hit selector and its bind to the top level
`default_nettype none

module hsd_checker
    import hsd_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_m_tvalid,
    input wire                  i_m_tready,
    input wire [OUT_DATA_W-1:0] o_m_tdata,
    input wire                  o_m_tlast
);

    // reset leaves no result on the output
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result shown right after reset");

    // a stalled result stays
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast))
        else $error("stalled result changed");

    // an empty event closes in its only result
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[14] |-> o_m_tlast && (o_m_tdata[13:0] == '0))
        else $error("empty result not final or not zero");

    // a kept hit never carries the dropped view
    a_view_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[14] |-> o_m_tdata[13:12] != VIEW_OTHER)
        else $error("kept hit with other view");

endmodule

bind hit_select_and_dedup hsd_checker u_hsd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
